[rtl/core/sorted_insert_table_unit_assert.svh]
// assertion macros for the sorted insert table checker
// no dependencies; included by the checker file only
`ifndef SORTED_INSERT_TABLE_UNIT_ASSERT_SVH
`define SORTED_INSERT_TABLE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SIT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted insert table: assertion failed");

// next-cycle implication, disabled during reset
`define SIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted insert table: assertion failed");

`endif

[rtl/core/sit_pkg.sv]
// shared types and constants of the sorted insert table
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package sit_pkg;

  // default table depth
  localparam int unsigned CAPACITY_DEF = 64;

  // fixed field widths
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned FILL_W   = 7;

  // request opcodes
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

  // one finished result
  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  position;
    logic [FILL_W-1:0] fill_count;
  } res_t;

endpackage

[rtl/core/sit_table_mem.sv]
// entry storage: one write port, one read port, registered read data
// depends on sit_pkg for the data width
`timescale 1ns / 1ps

module sit_table_mem #(
  parameter int unsigned Depth = sit_pkg::CAPACITY_DEF
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth)-1:0]         waddr_i,
  input  logic [sit_pkg::DATA_W-1:0]       wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth)-1:0]         raddr_i,
  output logic [sit_pkg::DATA_W-1:0]       rdata_o
);

  logic [sit_pkg::DATA_W-1:0] mem_q [Depth];
  logic [sit_pkg::DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/sit_seq.sv]
// insert and clear sequencer: scans the table upward, shifts the tail, places the value
// depends on sit_pkg; drives the ports of sit_table_mem
`timescale 1ns / 1ps

module sit_seq #(
  parameter int unsigned Capacity = sit_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic signed [sit_pkg::DATA_W-1:0]   value_i,
  output logic                                res_valid_o,
  output sit_pkg::res_t                       res_o,
  input  logic                                res_ready_i,
  output logic                                mem_we_o,
  output logic [$clog2(Capacity)-1:0]         mem_waddr_o,
  output logic [sit_pkg::DATA_W-1:0]          mem_wdata_o,
  output logic                                mem_re_o,
  output logic [$clog2(Capacity)-1:0]         mem_raddr_o,
  input  logic [sit_pkg::DATA_W-1:0]          mem_rdata_i
);

  localparam int unsigned AddrW  = $clog2(Capacity);
  localparam int unsigned CountW = $clog2(Capacity + 1);

  sit_pkg::state_e state_q, state_d;
  logic [CountW-1:0]                count_q, count_d;
  logic signed [sit_pkg::DATA_W-1:0] value_q;
  logic [AddrW-1:0]                 idx_q;
  logic [AddrW-1:0]                 pos_q;
  sit_pkg::status_e                 status_q;

  logic signed [sit_pkg::DATA_W-1:0] rdata;
  logic [CountW-1:0] idx_inc;
  logic [CountW-1:0] cnt_m1;
  logic              is_full;
  logic              is_clear;
  logic              scan_eq;
  logic              scan_gt;
  logic              scan_end;
  logic              scan_stop;
  logic [AddrW+sit_pkg::POS_W-1:0]   pos_x;
  logic [CountW+sit_pkg::FILL_W-1:0] cnt_x;

  // scan decisions on the entry read last cycle
  assign rdata     = $signed(mem_rdata_i);
  assign idx_inc   = CountW'(idx_q) + CountW'(1);
  assign cnt_m1    = count_q - CountW'(1);
  assign is_full   = (count_q == CountW'(Capacity));
  assign is_clear  = (opcode_i == sit_pkg::OP_CLEAR);
  assign scan_eq   = (rdata == value_q);
  assign scan_gt   = (rdata > value_q);
  assign scan_end  = (idx_inc == count_q);
  assign scan_stop = scan_eq || scan_gt || scan_end;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sit_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (is_clear) begin
            state_d = sit_pkg::S_DONE;
          end else if (count_q == '0) begin
            state_d = sit_pkg::S_PLACE;
          end else begin
            state_d = sit_pkg::S_SCAN;
          end
        end
      end
      sit_pkg::S_SCAN: begin
        if (scan_eq) begin
          state_d = sit_pkg::S_DONE;
        end else if (scan_stop) begin
          if (is_full) begin
            state_d = sit_pkg::S_DONE;
          end else if (scan_gt) begin
            state_d = sit_pkg::S_SHIFT;
          end else begin
            state_d = sit_pkg::S_PLACE;
          end
        end
      end
      sit_pkg::S_SHIFT: begin
        if (idx_q == pos_q) begin
          state_d = sit_pkg::S_PLACE;
        end
      end
      sit_pkg::S_PLACE: begin
        state_d = sit_pkg::S_DONE;
      end
      sit_pkg::S_DONE: begin
        if (res_ready_i) begin
          state_d = sit_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sit_pkg::S_IDLE;
      end
    endcase
  end

  // memory accesses and handshake outputs
  always_comb begin
    mem_re_o    = 1'b0;
    mem_raddr_o = '0;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = value_q;
    in_stall_o  = (state_q != sit_pkg::S_IDLE);
    res_valid_o = 1'b0;
    case (state_q)
      sit_pkg::S_IDLE: begin
        // first entry of the scan
        mem_re_o = in_valid_i && !is_clear && (count_q != '0);
      end
      sit_pkg::S_SCAN: begin
        if (!scan_stop) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_inc[AddrW-1:0];
        end else if (scan_gt && !scan_eq && !is_full) begin
          // top entry starts the shift
          mem_re_o    = 1'b1;
          mem_raddr_o = cnt_m1[AddrW-1:0];
        end
      end
      sit_pkg::S_SHIFT: begin
        // move entry idx up by one while reading the one below
        mem_we_o    = 1'b1;
        mem_waddr_o = idx_inc[AddrW-1:0];
        mem_wdata_o = mem_rdata_i;
        if (idx_q != pos_q) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = idx_q - AddrW'(1);
        end
      end
      sit_pkg::S_PLACE: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = pos_q;
      end
      sit_pkg::S_DONE: begin
        res_valid_o = 1'b1;
      end
      default: begin
        mem_re_o = 1'b0;
      end
    endcase
  end

  // entry count update
  always_comb begin
    count_d = count_q;
    if (state_q == sit_pkg::S_IDLE && in_valid_i && is_clear) begin
      count_d = '0;
    end else if (state_q == sit_pkg::S_PLACE) begin
      count_d = count_q + CountW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sit_pkg::S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // working registers of the current request
  always_ff @(posedge clk_i) begin
    case (state_q)
      sit_pkg::S_IDLE: begin
        if (in_valid_i) begin
          value_q  <= value_i;
          idx_q    <= '0;
          pos_q    <= '0;
          status_q <= sit_pkg::ST_DONE;
        end
      end
      sit_pkg::S_SCAN: begin
        if (scan_eq) begin
          status_q <= sit_pkg::ST_DUP;
          pos_q    <= '0;
        end else if (scan_stop) begin
          if (is_full) begin
            status_q <= sit_pkg::ST_FULL;
            pos_q    <= '0;
          end else begin
            pos_q <= scan_gt ? idx_q : idx_inc[AddrW-1:0];
            idx_q <= cnt_m1[AddrW-1:0];
          end
        end else begin
          idx_q <= idx_inc[AddrW-1:0];
        end
      end
      sit_pkg::S_SHIFT: begin
        idx_q <= idx_q - AddrW'(1);
      end
      default: begin
        idx_q <= idx_q;
      end
    endcase
  end

  // result fields, masked to the port widths
  assign pos_x = {{sit_pkg::POS_W{1'b0}}, pos_q};
  assign cnt_x = {{sit_pkg::FILL_W{1'b0}}, count_q};

  assign res_o.status     = status_q;
  assign res_o.position   = pos_x[sit_pkg::POS_W-1:0];
  assign res_o.fill_count = cnt_x[sit_pkg::FILL_W-1:0];

endmodule

[rtl/core/sorted_insert_table_unit.sv]
// top level of the sorted insert table: sequencer, entry memory, result register
// depends on sit_pkg, sit_seq and sit_table_mem
//
//   channel  direction  handshake              payload
//   request  in         in_valid_i/in_stall_o  opcode_i, value_i
//   result   out        out_valid_o/out_stall_i status_o, position_o, fill_count_o
//
// an insert into a table of n entries placed at position p runs as a scan
// and a shift: the scan reads one entry a cycle up to p, the shift moves
// one entry a cycle from n-1 down to p, both over the single memory read port
// a clear skips the scan and the shift; one request is in work at a time
// reset clears the count and the handshake state; entries need no clearing
// a stalled result sits in the output register while the next request runs
`timescale 1ns / 1ps

module sorted_insert_table_unit #(
  parameter int unsigned Capacity = sit_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [sit_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sit_pkg::STATUS_W-1:0]      status_o,
  output logic [sit_pkg::POS_W-1:0]         position_o,
  output logic [sit_pkg::FILL_W-1:0]        fill_count_o
);

  localparam int unsigned AddrW = $clog2(Capacity);

  logic                       res_valid;
  logic                       res_ready;
  sit_pkg::res_t              res;
  logic                       mem_we;
  logic [AddrW-1:0]           mem_waddr;
  logic [sit_pkg::DATA_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AddrW-1:0]           mem_raddr;
  logic [sit_pkg::DATA_W-1:0] mem_rdata;

  logic          out_valid_q, out_valid_d;
  sit_pkg::res_t out_res_q;

  sit_seq #(
    .Capacity (Capacity)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_i     (value_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  sit_table_mem #(
    .Depth (Capacity)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register is free when empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_res_q.status;
  assign position_o   = out_res_q.position;
  assign fill_count_o = out_res_q.fill_count;

endmodule

[rtl/core/sit_checker.sv]
// port-level checks of the sorted insert table, bound to the top level
// depends on sit_pkg and sorted_insert_table_unit_assert.svh
`timescale 1ns / 1ps

`include "sorted_insert_table_unit_assert.svh"

module sit_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [sit_pkg::STATUS_W-1:0] status_o,
  input logic [sit_pkg::POS_W-1:0]    position_o,
  input logic [sit_pkg::FILL_W-1:0]   fill_count_o
);

  // a stalled result holds
  `SIT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(status_o) && $stable(position_o) && $stable(fill_count_o))

  // only defined status codes leave the block
  `SIT_ASSERT_IMPL(a_status_code, clk_i, rst_ni, out_valid_o, status_o == sit_pkg::ST_DONE || status_o == sit_pkg::ST_DUP || status_o == sit_pkg::ST_FULL)

  // rejected inserts report position zero
  `SIT_ASSERT_IMPL(a_reject_pos, clk_i, rst_ni, out_valid_o && status_o != sit_pkg::ST_DONE, position_o == '0)

  // one request in work at a time
  `SIT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

endmodule

bind sorted_insert_table_unit sit_checker u_sit_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .position_o   (position_o),
  .fill_count_o (fill_count_o)
);
